// ----- hdl/bps_pkg.sv -----
`default_nettype none

package bps_pkg;

  // Fixed field widths
  localparam int DIM_W      = 13;           // image / mark dimension registers
  localparam int OFFS_W     = 24;           // start offset register
  localparam int SIZE_W     = 2 * DIM_W;    // mark_width * mark_height
  localparam int SAMPLE_W   = 16;           // width of one color sample
  localparam int SEL_W      = $clog2(SAMPLE_W);
  localparam int COORD_W    = 12;           // pixel_column / pixel_row fields
  localparam int PLANE_OUT_W = 4;           // bit_plane field
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_MARK_WIDTH   = 3'd2,
    REG_MARK_HEIGHT  = 3'd3,
    REG_START_OFFSET = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] green_sample;
    logic [SAMPLE_W-1:0] blue_sample;
  } pix_t;

  typedef struct packed {
    logic [COORD_W-1:0]     pixel_column;
    logic [COORD_W-1:0]     pixel_row;
    logic [PLANE_OUT_W-1:0] bit_plane;
    logic                   bit_value;
    logic                   last_write;
  } wr_t;

  // Settings handed from the register block to the datapath
  typedef struct packed {
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  rows;
    logic [SIZE_W-1:0] mark_size;
    logic [OFFS_W-1:0] start_offset;
    logic              restart;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/bps_if.sv -----
`default_nettype none

interface bps_pix_if import bps_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bps_wr_if import bps_pkg::*; ();
  logic valid;
  logic ready;
  wr_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/bps_cfg.sv -----
`default_nettype none

module bps_cfg import bps_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [DIM_W-1:0]  mark_width;
  logic [DIM_W-1:0]  mark_height;
  logic [OFFS_W-1:0] start_offset;
  logic [SIZE_W-1:0] mark_size;
  logic              restart;
  logic              wr_en;
  reg_idx_t          idx;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
      mark_width   <= DIM_W'(1);
      mark_height  <= DIM_W'(1);
      start_offset <= '0;
      restart      <= 1'b0;
    end else begin
      restart <= 1'b0;
      if (wr_en) begin
        unique case (idx)
          REG_IMAGE_WIDTH: begin
            image_width <= pwdata[DIM_W-1:0];
            restart     <= 1'b1;
          end
          REG_IMAGE_HEIGHT: begin
            image_height <= pwdata[DIM_W-1:0];
            restart      <= 1'b1;
          end
          REG_MARK_WIDTH: begin
            mark_width <= pwdata[DIM_W-1:0];
            restart    <= 1'b1;
          end
          REG_MARK_HEIGHT: begin
            mark_height <= pwdata[DIM_W-1:0];
            restart     <= 1'b1;
          end
          REG_START_OFFSET: begin
            start_offset <= pwdata[OFFS_W-1:0];
            restart      <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Product is registered from the stored mark dimensions and updates after the restart pulse lands
  always_ff @(posedge clk) begin
    mark_size <= clamp_dim(mark_width) * clamp_dim(mark_height);
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      REG_MARK_WIDTH:   prdata = APB_DATA_W'(mark_width);
      REG_MARK_HEIGHT:  prdata = APB_DATA_W'(mark_height);
      REG_START_OFFSET: prdata = APB_DATA_W'(start_offset);
      default:          prdata = '0;
    endcase
  end

  assign cfg.cols         = clamp_dim(image_width);
  assign cfg.rows         = clamp_dim(image_height);
  assign cfg.mark_size    = mark_size;
  assign cfg.start_offset = start_offset;
  assign cfg.restart      = restart;

endmodule

`default_nettype wire

// ----- hdl/bps_core.sv -----
`default_nettype none

module bps_core import bps_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  bps_pix_if.sink   pix,
  bps_wr_if.source  wr
);

  localparam int WRAP_W  = $clog2(SAMPLE_BITS + 1);
  localparam int PLANE_W = $clog2(SAMPLE_BITS);

  typedef enum logic [1:0] {
    PH_RED   = 2'd0,
    PH_GREEN = 2'd1,
    PH_BLUE  = 2'd2
  } phase_t;

  // Input register
  logic s1_valid;
  pix_t s1_data;
  logic advance;
  logic step;

  // Scatter state
  phase_t             phase, phase_next;
  logic [SIZE_W-1:0]  pos, pos_next, pos_inc;
  logic [WRAP_W-1:0]  wrap_cnt, wrap_next;
  logic [PLANE_W-1:0] plane, plane_next;
  logic [DIM_W-1:0]   col, col_next, col_inc;
  logic [DIM_W-1:0]   row, row_next, row_inc;
  logic               finished, finished_next;

  logic [SAMPLE_W-1:0] sample;
  logic                bit_val;
  logic                produce;

  // Output register
  logic out_valid;
  wr_t  out_data;

  assign advance   = !out_valid || wr.ready;
  assign pix.ready = !s1_valid || advance;
  assign step      = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix.ready) begin
      s1_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.ready && pix.valid) begin
      s1_data <= pix.data;
    end
  end

  always_comb begin
    unique case (phase)
      PH_RED:   sample = s1_data.red_sample;
      PH_GREEN: sample = s1_data.green_sample;
      default:  sample = s1_data.blue_sample;
    endcase
    bit_val = (32'(wrap_cnt) < SAMPLE_W) ? sample[wrap_cnt[SEL_W-1:0]] : 1'b0;

    produce = !finished && (pos < cfg.mark_size);

    unique case (phase)
      PH_RED:   phase_next = PH_GREEN;
      PH_GREEN: phase_next = PH_BLUE;
      default:  phase_next = PH_RED;
    endcase

    pos_inc  = pos + SIZE_W'(1);
    pos_next = (pos_inc == cfg.mark_size) ? '0 : pos_inc;
    // a wrap back to the start offset moves to the next sample bit
    wrap_next = (pos_next == SIZE_W'(cfg.start_offset)) ? wrap_cnt + WRAP_W'(1) : wrap_cnt;
    finished_next = (wrap_next == WRAP_W'(SAMPLE_BITS));

    col_inc    = col + DIM_W'(1);
    row_inc    = row + DIM_W'(1);
    col_next   = col_inc;
    row_next   = row;
    plane_next = plane;
    if (col_inc >= cfg.cols) begin
      col_next = '0;
      row_next = row_inc;
      if (row_inc >= cfg.rows) begin
        row_next = '0;
        if (plane == '0) begin
          finished_next = 1'b1;
        end else begin
          plane_next = plane - PLANE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      phase    <= PH_RED;
      pos      <= rst ? '0 : SIZE_W'(cfg.start_offset);
      wrap_cnt <= '0;
      plane    <= PLANE_W'(SAMPLE_BITS - 1);
      col      <= '0;
      row      <= '0;
      finished <= 1'b0;
    end else if (step) begin
      if (produce) begin
        phase    <= phase_next;
        pos      <= pos_next;
        wrap_cnt <= wrap_next;
        plane    <= plane_next;
        col      <= col_next;
        row      <= row_next;
        finished <= finished_next;
      end else begin
        // start offset outside the mark, or already done
        finished <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.pixel_column <= COORD_W'(col);
      out_data.pixel_row    <= COORD_W'(row);
      out_data.bit_plane    <= PLANE_OUT_W'(plane);
      out_data.bit_value    <= bit_val;
      out_data.last_write   <= finished_next;
    end
  end

  assign wr.valid = out_valid;
  assign wr.data  = out_data;

  a_no_write_when_done: assert property (@(posedge clk) disable iff (rst)
    finished && step |=> !out_valid)
    else $error("write issued after extraction finished");

  a_wrap_bounded: assert property (@(posedge clk) disable iff (rst)
    !finished |-> (32'(wrap_cnt) < SAMPLE_BITS))
    else $error("wrap count reached sample width without finishing");

  // new image size lands while restart is high, before the raster position is cleared
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    !cfg.restart |-> (col < cfg.cols && row < cfg.rows))
    else $error("output raster position outside image");

  a_plane_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(plane) < SAMPLE_BITS)
    else $error("bit plane above top plane");

endmodule

`default_nettype wire

// ----- hdl/stego_bitplane_scatter_top.sv -----
`default_nettype none

// Channel  Kind          Payload
// pix      valid/ready   red_sample, green_sample, blue_sample (16b each)
// wr       valid/ready   pixel_column, pixel_row, bit_plane, bit_value, last_write
// apb      psel/penable  image_width, image_height, mark_width, mark_height, start_offset
//
// One request per cycle sustained while wr is ready; a result passes through the input register,
// then the result register; the counter update fits between them.
// A request that yields no write (after the end, or offset outside the mark) is dropped.
// rst is synchronous; registers take their reset values and the scan restarts.
// Any register write restarts the scan through the registered restart pulse.
// A stall on wr holds the result register and backs up into the input register.

module stego_bitplane_scatter_top import bps_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_DIM     = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bps_pix_if.sink                    pix,
  bps_wr_if.source                   wr,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t cfg;

  bps_cfg #(
    .MAX_DIM(MAX_DIM)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bps_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .pix (pix),
    .wr  (wr)
  );

endmodule

`default_nettype wire
